// ----- design/tod_pkg.sv -----
// Shared types and constants of the time-of-day pulse tracker.
// No dependencies; compiled first.
package tod_pkg;

   // operation codes of an input word
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_PULSE = 2'd1;
   localparam logic [1:0] OP_LOAD  = 2'd2;

   // field widths
   localparam int unsigned SEC_W   = 17;
   localparam int unsigned MICRO_W = 24;
   localparam int unsigned US_W    = 20;
   localparam int unsigned CNT_W   = 32;

   // configuration port
   localparam int unsigned PADDR_W = 3;
   localparam int unsigned PDATA_W = 32;
   localparam logic        CSR_IDX_LOSS_THRESHOLD = 1'b0;

   // microsecond constants
   localparam logic [MICRO_W-1:0] MICRO_MAX     = 24'hFFFFFF;
   localparam logic [MICRO_W-1:0] THRESH_RESET  = 24'd1000100;
   localparam logic [MICRO_W-1:0] ONE_SECOND_US = 24'd1000000;
   localparam logic [US_W-1:0]    CLAMP_US      = 20'd999999;

   typedef struct packed {
      logic [1:0]       op;
      logic             reference_bit;
      logic [SEC_W-1:0] load_seconds;
   } req_word_type;

   typedef struct packed {
      logic             time_valid;
      logic [SEC_W-1:0] seconds_of_day;
      logic [US_W-1:0]  microseconds;
      logic             clock_loss;
      logic             clock_loss_sticky;
      logic [CNT_W-1:0] interrupt_count;
      logic [CNT_W-1:0] valid_pulse_count;
   } rsp_word_type;

endpackage

// ----- design/tod_if.sv -----
// Valid/ready channel interfaces for the tracker's input and result words.
// Depends on tod_pkg for field widths.
interface tod_req_if;
   import tod_pkg::*;

   logic             valid;
   logic             ready;
   logic [1:0]       op;
   logic             reference_bit;
   logic [SEC_W-1:0] load_seconds;

   modport source (output valid, op, reference_bit, load_seconds, input ready);
   modport sink   (input valid, op, reference_bit, load_seconds, output ready);
endinterface

interface tod_rsp_if;
   import tod_pkg::*;

   logic             valid;
   logic             ready;
   logic             time_valid;
   logic [SEC_W-1:0] seconds_of_day;
   logic [US_W-1:0]  microseconds;
   logic             clock_loss;
   logic             clock_loss_sticky;
   logic [CNT_W-1:0] interrupt_count;
   logic [CNT_W-1:0] valid_pulse_count;

   modport source (output valid, time_valid, seconds_of_day, microseconds, clock_loss,
                   clock_loss_sticky, interrupt_count, valid_pulse_count, input ready);
   modport sink   (input valid, time_valid, seconds_of_day, microseconds, clock_loss,
                   clock_loss_sticky, interrupt_count, valid_pulse_count, output ready);
endinterface

// ----- design/time_of_day_pulse_tracker_top.sv -----
// Top level of the time-of-day pulse tracker: channels, register port, checks.
// Depends on tod_pkg, tod_if, tod_csr and tod_core.
//
// The tracker takes one word per clock unless the result channel stalls and
// answers each with one result word holding the time after that word's update.
// A word passes the input register, which captures the reciprocal multiply for
// a seconds load, then the update stage, which writes the state and the result
// register together. State feedback through the update stage is what holds
// the rate at one word per cycle. The result register parts the two channels,
// so an empty input register takes a new word while a finished result waits.
// The loss threshold sits at byte address 0 of the register port and resets to
// 1000100 microseconds; write it only while no word is in flight.
module time_of_day_pulse_tracker_top #(
   parameter int unsigned SECONDS_PER_DAY = 86400
) (
   input  logic                          clock,
   input  logic                          reset,
   tod_req_if.sink                       req,
   tod_rsp_if.source                     rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tod_pkg::PADDR_W-1:0]   paddr,
   input  logic [tod_pkg::PDATA_W-1:0]   pwdata,
   output logic [tod_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);
   import tod_pkg::*;

   logic [MICRO_W-1:0] loss_threshold;
   req_word_type       req_word;
   rsp_word_type       rsp_word;

   tod_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .loss_threshold (loss_threshold)
   );

   // pack the input word
   assign req_word.op            = req.op;
   assign req_word.reference_bit = req.reference_bit;
   assign req_word.load_seconds  = req.load_seconds;

   tod_core #(
      .SECONDS_PER_DAY (SECONDS_PER_DAY)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .loss_threshold (loss_threshold),
      .req_valid      (req.valid),
      .req_ready      (req.ready),
      .req_word       (req_word),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_word       (rsp_word)
   );

   // unpack the result word
   assign rsp.time_valid        = rsp_word.time_valid;
   assign rsp.seconds_of_day    = rsp_word.seconds_of_day;
   assign rsp.microseconds      = rsp_word.microseconds;
   assign rsp.clock_loss        = rsp_word.clock_loss;
   assign rsp.clock_loss_sticky = rsp_word.clock_loss_sticky;
   assign rsp.interrupt_count   = rsp_word.interrupt_count;
   assign rsp.valid_pulse_count = rsp_word.valid_pulse_count;

   // seconds always within one day
   a_seconds_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.seconds_of_day < SEC_W'(SECONDS_PER_DAY)))
      else $error("seconds of day out of range");

   // no time shown before a load
   a_seconds_unset: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.time_valid) |-> (rsp.seconds_of_day == '0))
      else $error("seconds shown while time not set");

   // microseconds clamped below one second
   a_micro_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.microseconds <= CLAMP_US))
      else $error("microseconds not clamped");

   // a flagged loss is always recorded in the sticky flag
   a_loss_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.clock_loss) |-> rsp.clock_loss_sticky)
      else $error("clock loss without sticky flag");

endmodule

// ----- design/tod_csr.sv -----
// APB-style register block holding the clock-loss threshold.
// Depends on tod_pkg.
module tod_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tod_pkg::PADDR_W-1:0]    paddr,
   input  logic [tod_pkg::PDATA_W-1:0]    pwdata,
   output logic [tod_pkg::PDATA_W-1:0]    prdata,
   output logic                           pready,
   output logic [tod_pkg::MICRO_W-1:0]    loss_threshold
);
   import tod_pkg::*;

   logic [MICRO_W-1:0] thresh_ff;
   logic [MICRO_W-1:0] thresh_in;
   logic               wr_hit;

   // word index sits above the byte offset
   assign wr_hit = psel && penable && pwrite && (paddr[2] == CSR_IDX_LOSS_THRESHOLD);

   always_comb begin
      thresh_in = thresh_ff;
      if (wr_hit) begin
         thresh_in = pwdata[MICRO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   // read back
   assign prdata = (paddr[2] == CSR_IDX_LOSS_THRESHOLD) ?
                   {{(PDATA_W-MICRO_W){1'b0}}, thresh_ff} : '0;
   assign pready = 1'b1;
   assign loss_threshold = thresh_ff;

endmodule

// ----- design/tod_core.sv -----
// Tracker datapath: input register, state update and result register.
// Depends on tod_pkg.
module tod_core #(
   parameter int unsigned SECONDS_PER_DAY = 86400
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tod_pkg::MICRO_W-1:0]   loss_threshold,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tod_pkg::req_word_type         req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tod_pkg::rsp_word_type         rsp_word
);
   import tod_pkg::*;

   // reciprocal for the load reduction: q is floor(x/D) or one below it
   localparam int unsigned RECIP_SHIFT = 32;
   localparam logic [31:0] RECIP = 32'((64'd1 << RECIP_SHIFT) / SECONDS_PER_DAY);
   localparam logic [SEC_W-1:0] DAY_LEN = SEC_W'(SECONDS_PER_DAY);
   localparam int unsigned PROD_W = SEC_W + 32;

   // input stage
   logic               s1_valid_ff;
   req_word_type       s1_word_ff;
   logic [SEC_W-1:0]   s1_quot_ff;
   logic [PROD_W-1:0]  recip_prod;

   // tracker state
   logic [SEC_W-1:0]   seconds_ff, seconds_in;
   logic               seconds_set_ff, seconds_set_in;
   logic [MICRO_W-1:0] micro_ff, micro_in;
   logic               loss_ff, loss_in;
   logic               sticky_ff, sticky_in;
   logic [CNT_W-1:0]   events_ff, events_in;
   logic [CNT_W-1:0]   pulses_ff, pulses_in;

   // result stage
   logic               out_valid_ff;
   rsp_word_type       out_word_ff;
   rsp_word_type       out_word_in;

   logic               out_load;
   logic               s1_fire;
   logic [2*SEC_W-1:0] quot_times_day;
   logic [SEC_W:0]     load_rem;
   logic [SEC_W:0]     load_rem_fix;
   logic [SEC_W:0]     seconds_next;

   // handshake: the result register frees as it is taken
   assign out_load  = !out_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && out_load;
   assign req_ready = !s1_valid_ff || out_load;

   assign recip_prod = PROD_W'(req_word.load_seconds) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_word_ff <= req_word;
         s1_quot_ff <= recip_prod[RECIP_SHIFT +: SEC_W];
      end
   end

   // load reduction, at most one correction
   assign quot_times_day = (2*SEC_W)'(s1_quot_ff) * (2*SEC_W)'(DAY_LEN);
   assign load_rem       = (SEC_W+1)'(s1_word_ff.load_seconds) - quot_times_day[SEC_W:0];
   assign load_rem_fix   = (load_rem >= (SEC_W+1)'(DAY_LEN)) ?
                           load_rem - (SEC_W+1)'(DAY_LEN) : load_rem;

   assign seconds_next = (SEC_W+1)'(seconds_ff) + 1'b1;

   // state update for one word
   always_comb begin
      seconds_in     = seconds_ff;
      seconds_set_in = seconds_set_ff;
      micro_in       = micro_ff;
      loss_in        = loss_ff;
      sticky_in      = sticky_ff;
      events_in      = events_ff;
      pulses_in      = pulses_ff;
      case (s1_word_ff.op)
         OP_TICK: begin
            if (micro_ff != MICRO_MAX) begin
               micro_in = micro_ff + 1'b1;
            end
         end
         OP_PULSE: begin
            events_in = events_ff + 1'b1;
            if (s1_word_ff.reference_bit) begin
               pulses_in = pulses_ff + 1'b1;
               if (seconds_set_ff) begin
                  seconds_in = (seconds_next >= (SEC_W+1)'(DAY_LEN)) ?
                               '0 : seconds_next[SEC_W-1:0];
               end
               loss_in   = micro_ff > loss_threshold;
               sticky_in = sticky_ff || loss_in;
               micro_in  = '0;
            end
         end
         OP_LOAD: begin
            seconds_in     = load_rem_fix[SEC_W-1:0];
            seconds_set_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // result word from the updated state
   always_comb begin
      out_word_in.time_valid        = seconds_set_in;
      out_word_in.seconds_of_day    = seconds_set_in ? seconds_in : '0;
      if (micro_in > ONE_SECOND_US) begin
         out_word_in.microseconds = CLAMP_US;
      end else if (micro_in == ONE_SECOND_US) begin
         out_word_in.microseconds = '0;
      end else begin
         out_word_in.microseconds = micro_in[US_W-1:0];
      end
      out_word_in.clock_loss        = loss_in;
      out_word_in.clock_loss_sticky = sticky_in;
      out_word_in.interrupt_count   = events_in;
      out_word_in.valid_pulse_count = pulses_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seconds_ff     <= '0;
         seconds_set_ff <= 1'b0;
         micro_ff       <= '0;
         loss_ff        <= 1'b0;
         sticky_ff      <= 1'b0;
         events_ff      <= '0;
         pulses_ff      <= '0;
      end else if (s1_fire) begin
         seconds_ff     <= seconds_in;
         seconds_set_ff <= seconds_set_in;
         micro_ff       <= micro_in;
         loss_ff        <= loss_in;
         sticky_ff      <= sticky_in;
         events_ff      <= events_in;
         pulses_ff      <= pulses_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

// ----- test/tb_time_of_day_pulse_tracker_top.sv -----
// Self-checking testbench for the time-of-day pulse tracker: random valid/ready
// traffic, an in-bench tracker model, field-by-field result checks.
// Depends on tod_pkg, tod_if and the design top level.
`timescale 1ns / 100ps

module tb_time_of_day_pulse_tracker_top;
   import tod_pkg::*;

   localparam int unsigned DAY_SECONDS   = 86400;
   localparam logic [1:0]  OP_UNUSED     = 2'd3;
   localparam logic [PADDR_W-1:0] CSR_ADDR_LOSS  = {CSR_IDX_LOSS_THRESHOLD, 2'b00};
   localparam logic [PADDR_W-1:0] CSR_ADDR_SPARE = 3'd4;
   localparam int unsigned BURST_TICKS   = 40;
   localparam int unsigned TRAFFIC_WORDS = 220;
   localparam int unsigned SETTLE_CYCLES = 8;

   logic clock = 1'b0;
   logic reset;

   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   tod_req_if req_ch ();
   tod_rsp_if rsp_ch ();

   time_of_day_pulse_tracker_top #(
      .SECONDS_PER_DAY(DAY_SECONDS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // words waiting to be sent, and predicted times waiting to come back
   req_word_type pending_words[$];
   rsp_word_type predicted_times[$];
   req_word_type next_word;
   req_word_type taken_word;
   rsp_word_type want;

   // tracker model state and its copy of the threshold register
   logic [MICRO_W-1:0] loss_limit;
   logic [SEC_W-1:0]   tod_seconds;
   logic               tod_set;
   logic [MICRO_W-1:0] tod_micro;
   logic               tod_loss;
   logic               tod_sticky;
   logic [CNT_W-1:0]   tod_events;
   logic [CNT_W-1:0]   tod_pulses;

   int unsigned mismatches = 0;
   int unsigned req_gap = 0;
   int unsigned rsp_stall = 0;
   bit req_sent = 1'b0;
   bit rsp_taken = 1'b0;
   bit drv_calm = 1'b0;
   bit rcv_calm = 1'b0;
   bit steady_flow = 1'b0;

   always #5 clock = ~clock;

   // apply one word to the tracker model, return the time it reports
   function automatic rsp_word_type advance_tracker(req_word_type w);
      rsp_word_type r;
      logic [SEC_W:0] next_sec;
      case (w.op)
         OP_TICK: begin
            if (tod_micro != MICRO_MAX) tod_micro = tod_micro + 1'b1;
         end
         OP_PULSE: begin
            tod_events = tod_events + 1'b1;
            if (w.reference_bit) begin
               tod_pulses = tod_pulses + 1'b1;
               if (tod_set) begin
                  next_sec = tod_seconds + 1'b1;
                  tod_seconds = (next_sec >= DAY_SECONDS) ? '0 : next_sec[SEC_W-1:0];
               end
               tod_loss = tod_micro > loss_limit;
               if (tod_loss) tod_sticky = 1'b1;
               tod_micro = '0;
            end
         end
         OP_LOAD: begin
            tod_seconds = SEC_W'(w.load_seconds % DAY_SECONDS);
            tod_set = 1'b1;
         end
         default: ;
      endcase
      r.time_valid        = tod_set;
      r.seconds_of_day    = tod_set ? tod_seconds : '0;
      // one full second reads zero, anything beyond is clamped
      if (tod_micro > ONE_SECOND_US)
         r.microseconds = CLAMP_US;
      else if (tod_micro == ONE_SECOND_US)
         r.microseconds = '0;
      else
         r.microseconds = tod_micro[US_W-1:0];
      r.clock_loss        = tod_loss;
      r.clock_loss_sticky = tod_sticky;
      r.interrupt_count   = tod_events;
      r.valid_pulse_count = tod_pulses;
      return r;
   endfunction

   task automatic note_mismatch(string what, logic [31:0] exp_val, logic [31:0] got_val);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %0d, got %0d", what, exp_val, got_val);
   endtask

   task automatic push_word(logic [1:0] op, logic ref_bit, logic [SEC_W-1:0] secs);
      req_word_type w;
      w.op            = op;
      w.reference_bit = ref_bit;
      w.load_seconds  = secs;
      pending_words.push_back(w);
   endtask

   // random traffic, mostly whole seconds: ticks closed by a reference pulse
   task automatic push_traffic(int unsigned count);
      int unsigned made;
      int unsigned ticks;
      int unsigned pick;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            // tick runs sit right around a small threshold half of the time
            if (loss_limit < 48 && $urandom_range(0, 1)) begin
               ticks = loss_limit + $urandom_range(0, 2);
               if (ticks != 0) ticks = ticks - 1;
            end else begin
               ticks = $urandom_range(0, 40);
            end
            repeat (ticks) begin
               if ($urandom_range(0, 19) == 0) begin
                  push_word(OP_PULSE, 1'b0, SEC_W'($urandom()));
                  made++;
               end
               push_word(OP_TICK, 1'($urandom()), SEC_W'($urandom()));
               made++;
            end
            push_word(OP_PULSE, 1'b1, SEC_W'($urandom()));
         end else if (pick < 82) begin
            // loads, often close to midnight so the day wraps soon
            if ($urandom_range(0, 1))
               push_word(OP_LOAD, 1'($urandom()), SEC_W'($urandom_range(86395, 86399)));
            else
               push_word(OP_LOAD, 1'($urandom()), SEC_W'($urandom_range(0, 131071)));
         end else if (pick < 92) begin
            push_word(OP_PULSE, 1'b0, SEC_W'($urandom()));
         end else begin
            push_word(2'($urandom()), 1'($urandom()), SEC_W'($urandom()));
         end
         made++;
      end
   endtask

   // wait until every word is sent and answered, then let the pipe settle
   task automatic drain();
      while (pending_words.size() != 0 || req_ch.valid || predicted_times.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == CSR_ADDR_LOSS) loss_limit = data[MICRO_W-1:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_read_check(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] exp_val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== exp_val) note_mismatch("threshold readback", exp_val, prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // input side: note each accepted word and predict its time
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         taken_word.op            = req_ch.op;
         taken_word.reference_bit = req_ch.reference_bit;
         taken_word.load_seconds  = req_ch.load_seconds;
         predicted_times.push_back(advance_tracker(taken_word));
         req_sent = 1'b1;
      end
   end

   // input driver: random gap after each word, calm stretches without gaps
   always @(negedge clock) begin
      if (!reset && (!req_ch.valid || req_sent)) begin
         if (req_sent) begin
            req_sent = 1'b0;
            if ($urandom_range(0, 29) == 0) drv_calm = !drv_calm;
            req_gap = (steady_flow || drv_calm) ? 0 : $urandom_range(0, 9);
         end
         if (req_gap != 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            next_word = pending_words.pop_front();
            req_ch.op            <= next_word.op;
            req_ch.reference_bit <= next_word.reference_bit;
            req_ch.load_seconds  <= next_word.load_seconds;
            req_ch.valid         <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result side: compare each accepted word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_taken = 1'b1;
         if (predicted_times.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: result word with nothing pending");
         end else begin
            want = predicted_times.pop_front();
            if (rsp_ch.time_valid !== want.time_valid)
               note_mismatch("time_valid", 32'(want.time_valid), 32'(rsp_ch.time_valid));
            if (rsp_ch.seconds_of_day !== want.seconds_of_day)
               note_mismatch("seconds_of_day", 32'(want.seconds_of_day),
                             32'(rsp_ch.seconds_of_day));
            if (rsp_ch.microseconds !== want.microseconds)
               note_mismatch("microseconds", 32'(want.microseconds),
                             32'(rsp_ch.microseconds));
            if (rsp_ch.clock_loss !== want.clock_loss)
               note_mismatch("clock_loss", 32'(want.clock_loss), 32'(rsp_ch.clock_loss));
            if (rsp_ch.clock_loss_sticky !== want.clock_loss_sticky)
               note_mismatch("clock_loss_sticky", 32'(want.clock_loss_sticky),
                             32'(rsp_ch.clock_loss_sticky));
            if (rsp_ch.interrupt_count !== want.interrupt_count)
               note_mismatch("interrupt_count", want.interrupt_count, rsp_ch.interrupt_count);
            if (rsp_ch.valid_pulse_count !== want.valid_pulse_count)
               note_mismatch("valid_pulse_count", want.valid_pulse_count,
                             rsp_ch.valid_pulse_count);
         end
      end
   end

   // result ready: random stall after each word, calm stretches without stalls
   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         if ($urandom_range(0, 29) == 0) rcv_calm = !rcv_calm;
         rsp_stall = (steady_flow || rcv_calm) ? 0 : $urandom_range(0, 9);
      end
      if (rsp_stall != 0) begin
         rsp_stall--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // stimulus sequence
   initial begin
      logic [PDATA_W-1:0] new_limit;
      reset   = 1'b1;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      req_ch.valid         = 1'b0;
      req_ch.op            = OP_TICK;
      req_ch.reference_bit = 1'b0;
      req_ch.load_seconds  = '0;
      rsp_ch.ready         = 1'b0;
      loss_limit  = THRESH_RESET;
      tod_seconds = '0;
      tod_set     = 1'b0;
      tod_micro   = '0;
      tod_loss    = 1'b0;
      tod_sticky  = 1'b0;
      tod_events  = '0;
      tod_pulses  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_read_check(CSR_ADDR_LOSS, {8'd0, THRESH_RESET});

      // unused op, pulses before the time is set, out-of-range load, day wrap
      push_word(OP_UNUSED, 1'b1, 17'd5);
      push_word(OP_TICK, 1'b1, 17'h1FFFF);
      push_word(OP_TICK, 1'b0, 17'd0);
      push_word(OP_PULSE, 1'b0, 17'h1FFFF);
      push_word(OP_PULSE, 1'b1, 17'd0);
      push_word(OP_TICK, 1'b0, 17'd0);
      push_word(OP_LOAD, 1'b1, 17'h1FFFF);
      push_word(OP_PULSE, 1'b1, 17'd3);
      push_word(OP_LOAD, 1'b0, 17'd86399);
      push_word(OP_TICK, 1'b1, 17'd77);
      push_word(OP_PULSE, 1'b1, 17'h1FFFF);
      push_word(OP_LOAD, 1'b0, 17'd86400);
      push_word(OP_LOAD, 1'b1, 17'd0);
      push_word(OP_LOAD, 1'b0, 17'd86398);
      push_word(OP_UNUSED, 1'b0, 17'h1FFFF);
      push_word(OP_PULSE, 1'b1, 17'd0);
      drain();

      // a run of ticks at full rate, then pulses against the reset threshold
      steady_flow = 1'b1;
      repeat (BURST_TICKS) push_word(OP_TICK, 1'($urandom()), SEC_W'($urandom()));
      push_word(OP_PULSE, 1'b0, 17'd0);
      push_word(OP_TICK, 1'b0, 17'd0);
      push_word(OP_PULSE, 1'b1, 17'd0);
      push_word(OP_TICK, 1'b1, 17'd0);
      push_word(OP_PULSE, 1'b1, 17'd0);
      drain();
      steady_flow = 1'b0;

      // write beyond the register list has no effect
      csr_write(CSR_ADDR_SPARE, $urandom());
      csr_read_check(CSR_ADDR_LOSS, {8'd0, loss_limit});

      // random traffic under a range of thresholds, extremes first
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: new_limit = 32'd0;
            1: new_limit = 32'hFFFF_FFFF;
            6: new_limit = 32'd1;
            default: new_limit = ($urandom() & 32'hFF00_0000) | $urandom_range(2, 30);
         endcase
         csr_write(CSR_ADDR_LOSS, new_limit);
         csr_read_check(CSR_ADDR_LOSS, {8'd0, new_limit[MICRO_W-1:0]});
         push_traffic(TRAFFIC_WORDS);
         drain();
      end

      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #40ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
design/tod_pkg.sv
design/tod_if.sv
design/tod_csr.sv
design/tod_core.sv
design/time_of_day_pulse_tracker_top.sv
test/tb_time_of_day_pulse_tracker_top.sv
